// ----- rtl/core/rlec_pkg.sv -----
package rlec_pkg;

  localparam int BYTE_W      = 8;
  localparam int LANES       = 8;
  localparam int LANE_IDX_W  = 3;
  localparam int PTR_W       = 7;
  localparam int DEPTH       = 128;
  localparam int CNT_W       = 4;
  localparam int OUT_TDATA_W = 72;
  localparam int OUT_PAD_W   = OUT_TDATA_W - LANES * BYTE_W - CNT_W;

  // shortest run that is coded as a run
  localparam logic [PTR_W-1:0]  RUN_MIN = 7'd3;
  localparam logic [BYTE_W-1:0] RUN_HDR = 8'h80;

  // one coded segment: a run (header, value) or a literal stretch (length, bytes)
  typedef struct packed {
    logic              lit;
    logic [PTR_W-1:0]  len;
    logic [PTR_W-1:0]  ptr;
    logic [BYTE_W-1:0] val;
  } seg_t;

  typedef enum logic [2:0] {
    G_IDLE = 3'b001,
    G_HDR  = 3'b010,
    G_BODY = 3'b100
  } gen_state_t;

endpackage

// ----- rtl/core/rle_byte_compressor.sv -----
// the first result of an item passes the generator, data stage, packer and output register
// an item that codes nothing leaves in_tready high; an item that codes bytes holds in_tready
//   low until the generator has issued them, one coded byte per cycle while the packer takes them
// results leave via an output register at 1 per cycle while out_tready is high; packing goes on
// reset: synchronous active-low rst_n clears run/pending state, generator, packer and output;
//   the 128-entry pending memory is not cleared and needs no clearing pass
module rle_byte_compressor #(
  parameter int MAX_CHUNK = 127,
  parameter int OUT_LANES = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [rlec_pkg::BYTE_W-1:0]        in_tdata,   // [7:0] in_byte
  input  logic                               in_tlast,   // end_of_input
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [rlec_pkg::OUT_TDATA_W-1:0]   out_tdata,  // out_byte_0..7 [63:0], byte_count [67:64]
  output logic [0:0]                         out_tuser,  // [0] last_of_run
  output logic                               out_tlast   // end_of_output
);
  import rlec_pkg::*;

  localparam logic [PTR_W-1:0] MAX_C   = PTR_W'(MAX_CHUNK);
  localparam logic [CNT_W-1:0] LANES_C = CNT_W'(OUT_LANES);

  // coder state: pending bytes live in a circular buffer from head_r
  logic [PTR_W-1:0]  pend_cnt_r;
  logic [PTR_W-1:0]  run_cnt_r;
  logic [BYTE_W-1:0] run_val_r;
  logic [PTR_W-1:0]  head_r;

  logic [BYTE_W-1:0] pend_mem [DEPTH];
  logic [BYTE_W-1:0] mem_rd_r;

  // byte generator
  gen_state_t        gen_r;
  seg_t              cur_r;
  seg_t              segb_r;
  logic              segb_vld_r;
  logic              job_eoi_r;
  logic [PTR_W-1:0]  pos_r;

  // data stage, registered alongside the memory read data
  logic              d_valid_r;
  logic              d_mem_r;
  logic [BYTE_W-1:0] d_const_r;
  logic              d_end_r;
  logic              d_eoi_r;
  logic [BYTE_W-1:0] d_byte;

  // packer and output register
  logic [LANES-1:0][BYTE_W-1:0] pack_lane_r, pack_lane_nxt;
  logic [CNT_W-1:0]             pack_cnt_r, pack_cnt_nxt;
  logic                         pack_end_r, pack_end_nxt;
  logic                         pack_eoi_r, pack_eoi_nxt;
  logic [LANES-1:0][BYTE_W-1:0] out_lane_r;
  logic [CNT_W-1:0]             out_cnt_r;
  logic                         out_last_r;
  logic                         out_eoi_r;
  logic                         out_valid_r;

  // ---------------------------------------------------------------------------
  // per-item decision, taken from the state before the new byte joins
  // ---------------------------------------------------------------------------
  logic              in_acc;
  logic              match, brk, third, full, lit1, restart, seg1_on;
  logic [PTR_W-1:0]  lit_len, pend1, head1, waddr, pend2, run2;
  logic [BYTE_W-1:0] rv2;
  seg_t              seg1, seg2;

  assign in_acc = in_tvalid && in_tready;

  always_comb begin
    match   = (run_cnt_r == '0) || (in_tdata == run_val_r);
    // run at the size limit, or a coded-length run broken by a new byte
    brk     = (run_cnt_r >= MAX_C) || ((run_cnt_r >= RUN_MIN) && !match);
    // third equal byte after a literal stretch
    third   = !brk && (run_cnt_r == RUN_MIN - 7'd1) && match && (pend_cnt_r > RUN_MIN - 7'd1);
    full    = !brk && (pend_cnt_r >= MAX_C);
    lit1    = third || full;
    lit_len = third ? pend_cnt_r - (RUN_MIN - 7'd1) : pend_cnt_r;
    seg1_on = brk || lit1;

    if (brk) begin
      pend1 = '0;
    end else if (lit1) begin
      pend1 = pend_cnt_r - lit_len;
    end else begin
      pend1 = pend_cnt_r;
    end
    head1 = lit1 ? head_r + lit_len : head_r;
    waddr = head1 + pend1;
    pend2 = pend1 + 7'd1;

    restart = !match || brk || full;
    run2    = restart ? 7'd1 : run_cnt_r + 7'd1;
    rv2     = (restart || (run_cnt_r == '0)) ? in_tdata : run_val_r;

    seg1.lit = lit1;
    seg1.len = brk ? run_cnt_r : lit_len;
    seg1.ptr = head_r;
    seg1.val = run_val_r;

    // final flush at end of stream
    seg2.lit = run2 < RUN_MIN;
    seg2.len = (run2 < RUN_MIN) ? pend2 : run2;
    seg2.ptr = head1;
    seg2.val = rv2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_cnt_r <= '0;
      run_cnt_r  <= '0;
      run_val_r  <= '0;
      head_r     <= '0;
    end else if (in_acc) begin
      head_r <= head1;
      if (in_tlast) begin
        pend_cnt_r <= '0;
        run_cnt_r  <= '0;
        run_val_r  <= '0;
      end else begin
        pend_cnt_r <= pend2;
        run_cnt_r  <= run2;
        run_val_r  <= rv2;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // byte generator: header byte, then run value or literal bytes from memory
  // ---------------------------------------------------------------------------
  logic             stall, issue, seg_end, rd_en, i_mem, i_end;
  logic [BYTE_W-1:0] i_const;
  logic [PTR_W-1:0]  raddr;
  logic              pack_closed, flush, pack_take;

  assign in_tready = (gen_r == G_IDLE);
  assign stall     = d_valid_r && !pack_take;
  assign issue     = (gen_r != G_IDLE) && !stall;
  assign raddr     = cur_r.ptr + pos_r;

  always_comb begin
    i_mem   = 1'b0;
    i_const = run_val_r;
    seg_end = 1'b0;
    unique case (gen_r)
      G_HDR: begin
        i_const = cur_r.lit ? {1'b0, cur_r.len} : (RUN_HDR | {1'b0, cur_r.len});
      end
      G_BODY: begin
        i_const = cur_r.val;
        i_mem   = cur_r.lit;
        seg_end = cur_r.lit ? (pos_r == cur_r.len - 7'd1) : 1'b1;
      end
      default: begin
        i_const = cur_r.val;
      end
    endcase
    i_end = seg_end && !segb_vld_r;
    rd_en = issue && i_mem;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_r      <= G_IDLE;
      segb_vld_r <= 1'b0;
      job_eoi_r  <= 1'b0;
      pos_r      <= '0;
    end else begin
      unique case (gen_r)
        G_IDLE: begin
          if (in_acc) begin
            job_eoi_r <= in_tlast;
            if (seg1_on) begin
              cur_r      <= seg1;
              segb_r     <= seg2;
              segb_vld_r <= in_tlast;
              gen_r      <= G_HDR;
            end else if (in_tlast) begin
              cur_r <= seg2;
              gen_r <= G_HDR;
            end
          end
        end
        G_HDR: begin
          if (issue) begin
            pos_r <= '0;
            gen_r <= G_BODY;
          end
        end
        G_BODY: begin
          if (issue) begin
            pos_r <= pos_r + 7'd1;
            if (seg_end) begin
              if (segb_vld_r) begin
                cur_r      <= segb_r;
                segb_vld_r <= 1'b0;
                gen_r      <= G_HDR;
              end else begin
                gen_r <= G_IDLE;
              end
            end
          end
        end
        default: gen_r <= G_IDLE;
      endcase
    end
  end

  // pending store: write on accept, read while the generator runs, never both at once
  always_ff @(posedge clk) begin
    if (in_acc) begin
      pend_mem[waddr] <= in_tdata;
    end
    if (rd_en) begin
      mem_rd_r <= pend_mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r <= 1'b0;
    end else if (!stall) begin
      d_valid_r <= issue;
      if (issue) begin
        d_mem_r   <= i_mem;
        d_const_r <= i_const;
        d_end_r   <= i_end;
        d_eoi_r   <= job_eoi_r;
      end
    end
  end

  assign d_byte = d_mem_r ? mem_rd_r : d_const_r;

  // ---------------------------------------------------------------------------
  // packer: up to OUT_LANES bytes per result, closed early at the end of an item
  // ---------------------------------------------------------------------------
  assign pack_closed = (pack_cnt_r == LANES_C) || pack_end_r;
  assign flush       = pack_closed && (!out_valid_r || out_tready);
  assign pack_take   = d_valid_r && (!pack_closed || flush);

  always_comb begin
    pack_lane_nxt = pack_lane_r;
    pack_cnt_nxt  = pack_cnt_r;
    pack_end_nxt  = pack_end_r;
    pack_eoi_nxt  = pack_eoi_r;
    if (flush) begin
      pack_lane_nxt = '0;
      pack_cnt_nxt  = '0;
      pack_end_nxt  = 1'b0;
    end
    if (pack_take) begin
      pack_lane_nxt[pack_cnt_nxt[LANE_IDX_W-1:0]] = d_byte;
      pack_cnt_nxt  = pack_cnt_nxt + 4'd1;
      pack_end_nxt  = d_end_r;
      pack_eoi_nxt  = d_eoi_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pack_lane_r <= '0;
      pack_cnt_r  <= '0;
      pack_end_r  <= 1'b0;
      pack_eoi_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pack_lane_r <= pack_lane_nxt;
      pack_cnt_r  <= pack_cnt_nxt;
      pack_end_r  <= pack_end_nxt;
      pack_eoi_r  <= pack_eoi_nxt;
      if (flush) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (flush) begin
      out_lane_r <= pack_lane_r;
      out_cnt_r  <= pack_cnt_r;
      out_last_r <= pack_end_r;
      out_eoi_r  <= pack_end_r && pack_eoi_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_cnt_r, out_lane_r};
  assign out_tuser  = out_last_r;
  assign out_tlast  = out_eoi_r;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  a_stall_holds_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (d_valid_r && !pack_take) |=> (d_valid_r && $stable(d_byte)))
    else $error("byte in data stage changed while stalled");

  a_run_within_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (run_cnt_r <= pend_cnt_r) && (pend_cnt_r <= MAX_C))
    else $error("run or pending count out of range");

  a_result_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_cnt_r != '0) && (out_cnt_r <= LANES_C)))
    else $error("result byte count out of range");

  a_stream_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tlast) |=> ((pend_cnt_r == '0) && (run_cnt_r == '0)))
    else $error("coder state not cleared after end of stream");

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

  import rlec_pkg::*;

  // longest run or literal stretch the block codes in one piece
  localparam int MAX_LEN = 127;

  // one packed result as the block should deliver it
  typedef struct packed {
    logic [LANES-1:0][BYTE_W-1:0] lanes;  // lane 0 in the lowest bits
    logic [CNT_W-1:0]             cnt;
    logic                         run_end;     // last result of its item
    logic                         stream_end;  // last result of the stream
  } coded_word_t;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_tvalid;
  logic                     in_tready;
  logic [BYTE_W-1:0]        in_tdata;   // [7:0] in_byte
  logic                     in_tlast;   // end_of_input
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]   out_tdata;  // out_byte_0..7 [63:0], byte_count [67:64]
  logic [0:0]               out_tuser;  // [0] last_of_run
  logic                     out_tlast;  // end_of_output

  // encoder state as the block should hold it
  logic [BYTE_W-1:0] lit_buf [DEPTH];
  int                lit_cnt = 0;
  logic [PTR_W-1:0]  run_len = '0;
  logic [BYTE_W-1:0] run_val = '0;

  logic [BYTE_W-1:0] coded_bytes [$];  // bytes coded by the current item
  coded_word_t       coded_words [$];  // results still to arrive, oldest first
  coded_word_t       want;

  int mismatch_cnt   = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  always #5 clk = ~clk;

  rle_byte_compressor #(
    .MAX_CHUNK(MAX_LEN),
    .OUT_LANES(LANES)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic void emit_run();
    coded_bytes.push_back(RUN_HDR | {1'b0, run_len});
    coded_bytes.push_back(run_val);
  endfunction

  // code the oldest len pending bytes as literals, keep the rest in order
  function automatic void emit_literals(input int len);
    if (len > lit_cnt) len = lit_cnt;
    coded_bytes.push_back(BYTE_W'(len));
    for (int j = 0; j < len; j++) coded_bytes.push_back(lit_buf[j]);
    for (int j = 0; j < lit_cnt - len; j++) lit_buf[j] = lit_buf[j + len];
    lit_cnt -= len;
  endfunction

  // update the encoder with one item and queue the results it makes
  function automatic void encode_byte(input logic [BYTE_W-1:0] b, input logic eos);
    int          rl;
    int          pl;
    int          idx;
    int          cnt;
    logic        match;
    logic        restart;
    logic        third;
    logic        full;
    coded_word_t w;
    rl      = int'(run_len);
    pl      = lit_cnt;
    match   = (rl == 0) || (b == run_val);
    restart = !match;
    if (rl >= MAX_LEN || (rl >= int'(RUN_MIN) && !match)) begin
      // run at its limit or broken: code it, the new byte opens everything afresh
      emit_run();
      lit_cnt = 0;
      restart = 1'b1;
    end else begin
      // a third equal byte flushes the literals in front of the pair;
      // a full pending buffer flushes all of it and restarts the run
      third = (rl == 2) && match && (pl > 2);
      full  = pl >= MAX_LEN;
      if (third || full) emit_literals(third ? pl - 2 : pl);
      if (full) restart = 1'b1;
    end
    if (lit_cnt < DEPTH) begin
      lit_buf[lit_cnt] = b;
      lit_cnt++;
    end
    if (restart) begin
      run_len = 1;
      run_val = b;
    end else begin
      if (rl == 0) run_val = b;
      run_len = PTR_W'(rl + 1);
    end
    if (eos) begin
      if (run_len >= RUN_MIN) emit_run();
      else if (lit_cnt > 0) emit_literals(lit_cnt);
      lit_cnt = 0;
      run_len = '0;
      run_val = '0;
    end
    // pack the coded bytes eight to a result
    idx = 0;
    while (idx < coded_bytes.size()) begin
      w   = '0;
      cnt = coded_bytes.size() - idx;
      if (cnt > LANES) cnt = LANES;
      for (int j = 0; j < cnt; j++) w.lanes[j] = coded_bytes[idx + j];
      w.cnt        = CNT_W'(cnt);
      idx         += cnt;
      w.run_end    = (idx == coded_bytes.size());
      w.stream_end = eos && w.run_end;
      coded_words.push_back(w);
    end
    coded_bytes.delete();
  endfunction

  // ---------------------------------------------------------------------------
  // input side: one item per call, random idle cycles ahead of it
  // ---------------------------------------------------------------------------

  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eos);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eos;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    encode_byte(b, eos);
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // output side: random stalls, every accepted result checked in order
  // ---------------------------------------------------------------------------

  always @(negedge clk) out_tready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (coded_words.size() == 0) begin
        $display("%0t: result with nothing expected: tdata=%h tuser=%b tlast=%b",
                 $time, out_tdata, out_tuser, out_tlast);
        mismatch_cnt++;
      end else begin
        want = coded_words.pop_front();
        for (int j = 0; j < LANES; j++) begin
          if (out_tdata[j*BYTE_W +: BYTE_W] !== want.lanes[j]) begin
            $display("%0t: out_byte_%0d expected %h got %h",
                     $time, j, want.lanes[j], out_tdata[j*BYTE_W +: BYTE_W]);
            mismatch_cnt++;
          end
        end
        if (out_tdata[LANES*BYTE_W +: CNT_W] !== want.cnt) begin
          $display("%0t: byte_count expected %0d got %0d",
                   $time, want.cnt, out_tdata[LANES*BYTE_W +: CNT_W]);
          mismatch_cnt++;
        end
        // padding above the count is zero
        if (out_tdata[OUT_TDATA_W-1 -: OUT_PAD_W] !== '0) begin
          $display("%0t: tdata padding expected 0 got %h",
                   $time, out_tdata[OUT_TDATA_W-1 -: OUT_PAD_W]);
          mismatch_cnt++;
        end
        if (out_tuser[0] !== want.run_end) begin
          $display("%0t: last_of_run expected %b got %b", $time, want.run_end, out_tuser[0]);
          mismatch_cnt++;
        end
        if (out_tlast !== want.stream_end) begin
          $display("%0t: end_of_output expected %b got %b",
                   $time, want.stream_end, out_tlast);
          mismatch_cnt++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // short streams for the plain cases
  task automatic test_short_cases();
    // a lone byte at the stream end is one literal
    send_byte(8'h00, 1'b1);
    // two equal bytes stay literals
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    // a run of four closed by the stream end
    repeat (3) send_byte(8'h5A, 1'b0);
    send_byte(8'h5A, 1'b1);
    // third equal byte after a literal, then the run is broken
    send_byte(8'h12, 1'b0);
    repeat (3) send_byte(8'h34, 1'b0);
    send_byte(8'h56, 1'b1);
    // run broken by a pair that ends the stream as literals
    repeat (4) send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'h55, 1'b1);
    // mixed bit patterns as literals
    send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h01, 1'b1);
  endtask

  // streams of runs with random values and lengths, plus noise from a tiny alphabet
  task automatic test_random_streams(input int n_items);
    logic [BYTE_W-1:0] seq [$];
    logic [BYTE_W-1:0] v;
    logic              close;
    int                sent;
    int                target;
    int                seg_len;
    int                pick;
    sent = 0;
    while (sent < n_items) begin
      seq.delete();
      target = $urandom_range(12, 3);
      v      = $urandom;
      if ($urandom_range(9) < 7) begin
        while (seq.size() < target) begin
          // most runs take a new value, some merge with the one before
          if ($urandom_range(4) != 0) v = $urandom;
          pick = $urandom_range(19);
          if (pick < 13)      seg_len = $urandom_range(2, 1);
          else if (pick < 19) seg_len = $urandom_range(8, 3);
          else                seg_len = $urandom_range(12, 9);
          repeat (seg_len) seq.push_back(v);
        end
      end else begin
        repeat (target) seq.push_back(BYTE_W'($urandom_range(3)));
      end
      // some streams run on into the next one; the last one always ends
      close = (sent + seq.size() >= n_items) || ($urandom_range(7) != 0);
      foreach (seq[i]) send_byte(seq[i], close && (i == seq.size() - 1));
      sent += seq.size();
    end
  endtask

  // pending buffer fills up, the byte after it ends the stream: most results per item
  task automatic test_long_literals();
    logic [BYTE_W-1:0] prev;
    logic [BYTE_W-1:0] v;
    prev = $urandom;
    for (int i = 0; i < MAX_LEN + 1; i++) begin
      v = $urandom;
      if (v == prev) v = ~v;
      send_byte(v, i == MAX_LEN);
      prev = v;
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tlast  = 1'b0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // no idling
    test_short_cases();
    test_random_streams(8);

    // sender idle most of the time
    send_idle_pct = 74;
    test_random_streams(8);

    // receiver stalling most of the time, under the longest flush
    send_idle_pct  = 0;
    recv_stall_pct = 74;
    test_long_literals();

    // both sides idle now and then
    send_idle_pct  = 13;
    recv_stall_pct = 13;
    test_random_streams(8);

    in_tvalid      <= 1'b0;
    recv_stall_pct = 0;
    while (coded_words.size() != 0) @(posedge clk);
    // let any stray result show up
    repeat (200) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("FAIL");
    $finish;
  end

endmodule
